>>> rtl/redundant_link_reorder_dedup_macros.svh
// ----------------------------------------------------------------------------
// Redundant link reorder/dedup assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while i_rst_n low.
// ----------------------------------------------------------------------------
`ifndef REDUNDANT_LINK_REORDER_DEDUP_MACROS_SVH
`define REDUNDANT_LINK_REORDER_DEDUP_MACROS_SVH

// same-cycle implication
`define RLRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLRD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rlrd_pkg.sv
// ----------------------------------------------------------------------------
// Reorder/dedup package
// Sizes, status codes and interface structs shared by the reorder blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package rlrd_pkg;

    localparam int DEFER_DEPTH   = 16;
    localparam int WINDOW_FACTOR = 10;

    localparam int SEQ_W  = 32;
    localparam int PAY_W  = 32;
    localparam int ST_W   = 4;
    localparam int CFG_W  = 5;
    localparam int SLOT_W = (DEFER_DEPTH > 1) ? $clog2(DEFER_DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEFER_DEPTH + 1);
    localparam int WIN_W  = $clog2(DEFER_DEPTH * WINDOW_FACTOR + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic [ST_W-1:0] ST_DELIVERED = 4'd0;
    localparam logic [ST_W-1:0] ST_DEFERRED  = 4'd1;
    localparam logic [ST_W-1:0] ST_BAD_CRC   = 4'd2;
    localparam logic [ST_W-1:0] ST_FIRST_NZ  = 4'd3;
    localparam logic [ST_W-1:0] ST_OLD       = 4'd4;
    localparam logic [ST_W-1:0] ST_DUP       = 4'd5;
    localparam logic [ST_W-1:0] ST_FULL      = 4'd6;
    localparam logic [ST_W-1:0] ST_BEYOND    = 4'd7;
    localparam logic [ST_W-1:0] ST_TIMEOUT   = 4'd8;

    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] widx;
        logic [SEQ_W-1:0]  seq;
        logic [PAY_W-1:0]  pay;
        logic              clr;
        logic [SLOT_W-1:0] cidx;
    } t_store_req;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              free_vld;
        logic [SLOT_W-1:0] free_idx;
    } t_store_stat;

    function automatic logic [CNT_W-1:0] depth_clamp(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] d;
        if (c == '0) begin
            d = CNT_W'(1);
        end else if (int'(c) > DEFER_DEPTH) begin
            d = CNT_W'(DEFER_DEPTH);
        end else begin
            d = CNT_W'(c);
        end
        return d;
    endfunction

    function automatic logic [WIN_W-1:0] window_of(input logic [CNT_W-1:0] d);
        return WIN_W'(int'(d) * WINDOW_FACTOR);
    endfunction

endpackage

`default_nettype wire

>>> rtl/redundant_link_reorder_dedup.sv
// Classification rejects are decided in the check state, window rejects in the window state,
// defer and full at the end of the duplicate scan, duplicate as soon as that scan matches.
// Each delivered stored packet costs one comparator scan of the store;
// a final scan with no match closes the transaction. Timeout adds a min scan of every slot.
// One transaction at a time; busy is high from start until the last result strobes.
// Synchronous active-low reset empties the store, clears the expected sequence, depth = 16.
// ----------------------------------------------------------------------------
// Redundant link reorder and duplicate discard
// Merges packets from redundant links into one in-order stream with a
// defer store of out-of-order packets and a timeout flush.
// ----------------------------------------------------------------------------
`default_nettype none

module redundant_link_reorder_dedup (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rlrd_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_command,
    input  wire logic                          i_checksum_ok,
    input  wire logic                          i_tx_started,
    input  wire logic [rlrd_pkg::SEQ_W-1:0]    i_seq_number,
    input  wire logic [rlrd_pkg::PAY_W-1:0]    i_payload_tag,
    output logic                               o_strobe,
    output logic [rlrd_pkg::ST_W-1:0]          o_status,
    output logic                               o_has_data,
    output logic [rlrd_pkg::SEQ_W-1:0]         o_out_seq,
    output logic [rlrd_pkg::PAY_W-1:0]         o_out_payload,
    output logic                               o_last
);

    logic [rlrd_pkg::CNT_W-1:0]  r_depth, n_depth;
    logic [rlrd_pkg::WIN_W-1:0]  r_window, n_window;

    rlrd_pkg::t_store_req        store_req;
    rlrd_pkg::t_store_stat       store_stat;
    logic [rlrd_pkg::SLOT_W-1:0] store_ridx;
    logic                        store_rd_valid;
    logic [rlrd_pkg::SEQ_W-1:0]  store_rd_seq;
    logic [rlrd_pkg::PAY_W-1:0]  store_rd_pay;

    always_comb begin
        n_depth  = r_depth;
        n_window = r_window;
        if (i_cfg_we) begin
            n_depth  = rlrd_pkg::depth_clamp(i_cfg_data);
            n_window = rlrd_pkg::window_of(rlrd_pkg::depth_clamp(i_cfg_data));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= rlrd_pkg::depth_clamp(rlrd_pkg::CFG_RESET);
            r_window <= rlrd_pkg::window_of(rlrd_pkg::depth_clamp(rlrd_pkg::CFG_RESET));
        end else begin
            r_depth  <= n_depth;
            r_window <= n_window;
        end
    end

    rlrd_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .i_ridx     (store_ridx),
        .o_rd_valid (store_rd_valid),
        .o_rd_seq   (store_rd_seq),
        .o_rd_pay   (store_rd_pay),
        .o_stat     (store_stat)
    );

    rlrd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_command     (i_command),
        .i_checksum_ok (i_checksum_ok),
        .i_tx_started  (i_tx_started),
        .i_seq_number  (i_seq_number),
        .i_payload_tag (i_payload_tag),
        .i_depth       (r_depth),
        .i_window      (r_window),
        .o_req         (store_req),
        .o_ridx        (store_ridx),
        .i_rd_valid    (store_rd_valid),
        .i_rd_seq      (store_rd_seq),
        .i_rd_pay      (store_rd_pay),
        .i_stat        (store_stat),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_has_data    (o_has_data),
        .o_out_seq     (o_out_seq),
        .o_out_payload (o_out_payload),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

>>> rtl/rlrd_store.sv
// ----------------------------------------------------------------------------
// Defer store
// Slot registers for sequence and payload with valid bits, one scan read
// port, occupancy count and lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "redundant_link_reorder_dedup_macros.svh"

module rlrd_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rlrd_pkg::t_store_req          i_req,
    input  wire logic [rlrd_pkg::SLOT_W-1:0]   i_ridx,
    output logic                               o_rd_valid,
    output logic [rlrd_pkg::SEQ_W-1:0]         o_rd_seq,
    output logic [rlrd_pkg::PAY_W-1:0]         o_rd_pay,
    output rlrd_pkg::t_store_stat              o_stat
);

    logic [rlrd_pkg::DEFER_DEPTH-1:0] r_valid;
    logic [rlrd_pkg::DEFER_DEPTH-1:0] n_valid;
    logic [rlrd_pkg::SEQ_W-1:0]       r_seq [rlrd_pkg::DEFER_DEPTH];
    logic [rlrd_pkg::PAY_W-1:0]       r_pay [rlrd_pkg::DEFER_DEPTH];

    always_comb begin
        n_valid = r_valid;
        if (i_req.wr) begin
            n_valid[i_req.widx] = 1'b1;
        end
        if (i_req.clr) begin
            n_valid[i_req.cidx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_seq[i_req.widx] <= i_req.seq;
            r_pay[i_req.widx] <= i_req.pay;
        end
    end

    assign o_rd_valid = r_valid[i_ridx];
    assign o_rd_seq   = r_seq[i_ridx];
    assign o_rd_pay   = r_pay[i_ridx];

    always_comb begin
        o_stat.count    = rlrd_pkg::CNT_W'($countones(r_valid));
        o_stat.free_vld = 1'b0;
        o_stat.free_idx = '0;
        for (int i = rlrd_pkg::DEFER_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_stat.free_vld = 1'b1;
                o_stat.free_idx = rlrd_pkg::SLOT_W'(i);
            end
        end
    end

    `RLRD_ASSERT_IMP(a_wr_clr_excl, i_req.wr, !i_req.clr, "store write and clear together")
    `RLRD_ASSERT_IMP(a_wr_free, i_req.wr, !r_valid[i_req.widx], "store write into valid slot")
    `RLRD_ASSERT_IMP(a_clr_valid, i_req.clr, r_valid[i_req.cidx], "store clear of empty slot")

endmodule

`default_nettype wire

>>> rtl/rlrd_ctrl.sv
// ----------------------------------------------------------------------------
// Reorder sequencer
// Classifies each transaction and drives a shared equal/less-than comparator pair over the
// defer store for duplicate, minimum and flush scans; registers results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "redundant_link_reorder_dedup_macros.svh"

module rlrd_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic                          i_command,
    input  wire logic                          i_checksum_ok,
    input  wire logic                          i_tx_started,
    input  wire logic [rlrd_pkg::SEQ_W-1:0]    i_seq_number,
    input  wire logic [rlrd_pkg::PAY_W-1:0]    i_payload_tag,
    input  wire logic [rlrd_pkg::CNT_W-1:0]    i_depth,
    input  wire logic [rlrd_pkg::WIN_W-1:0]    i_window,
    output rlrd_pkg::t_store_req               o_req,
    output logic [rlrd_pkg::SLOT_W-1:0]        o_ridx,
    input  wire logic                          i_rd_valid,
    input  wire logic [rlrd_pkg::SEQ_W-1:0]    i_rd_seq,
    input  wire logic [rlrd_pkg::PAY_W-1:0]    i_rd_pay,
    input  wire rlrd_pkg::t_store_stat         i_stat,
    output logic                               o_strobe,
    output logic [rlrd_pkg::ST_W-1:0]          o_status,
    output logic                               o_has_data,
    output logic [rlrd_pkg::SEQ_W-1:0]         o_out_seq,
    output logic [rlrd_pkg::PAY_W-1:0]         o_out_payload,
    output logic                               o_last
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_WIN     = 3'd2;
    localparam logic [2:0] S_DUP     = 3'd3;
    localparam logic [2:0] S_MIN     = 3'd4;
    localparam logic [2:0] S_MIN_END = 3'd5;
    localparam logic [2:0] S_FLUSH   = 3'd6;

    localparam logic [rlrd_pkg::SLOT_W-1:0] LAST_IDX =
        rlrd_pkg::SLOT_W'(rlrd_pkg::DEFER_DEPTH - 1);

    logic [2:0]                    r_state, n_state;
    logic [rlrd_pkg::SLOT_W-1:0]   r_idx, n_idx;
    logic [rlrd_pkg::SEQ_W-1:0]    r_exp, n_exp;
    logic                          r_cmd, n_cmd;
    logic                          r_ck, n_ck;
    logic                          r_txs, n_txs;
    logic [rlrd_pkg::SEQ_W-1:0]    r_seq, n_seq;
    logic [rlrd_pkg::PAY_W-1:0]    r_pay, n_pay;
    logic                          r_found, n_found;
    logic [rlrd_pkg::SEQ_W-1:0]    r_best, n_best;
    logic [rlrd_pkg::ST_W-1:0]     r_fst, n_fst;
    logic                          r_pend_vld, n_pend_vld;
    logic [rlrd_pkg::SEQ_W-1:0]    r_pend_seq, n_pend_seq;
    logic [rlrd_pkg::PAY_W-1:0]    r_pend_pay, n_pend_pay;
    logic                          r_o_stb, n_o_stb;
    logic [rlrd_pkg::ST_W-1:0]     r_o_st, n_o_st;
    logic                          r_o_has, n_o_has;
    logic [rlrd_pkg::SEQ_W-1:0]    r_o_seq, n_o_seq;
    logic [rlrd_pkg::PAY_W-1:0]    r_o_pay, n_o_pay;
    logic                          r_o_last, n_o_last;

    logic [rlrd_pkg::SEQ_W-1:0]    cmp_key;
    logic                          cmp_eq;
    logic                          cmp_lt;
    logic [rlrd_pkg::SEQ_W:0]      win_limit;
    logic                          single_vld;
    logic [rlrd_pkg::ST_W-1:0]     single_st;

    always_comb begin
        if (r_state == S_MIN) begin
            cmp_key = r_best;
        end else if (r_state == S_DUP) begin
            cmp_key = r_seq;
        end else begin
            cmp_key = r_exp;
        end
        cmp_eq = (i_rd_seq == cmp_key);
        cmp_lt = (i_rd_seq < cmp_key);
    end

    assign win_limit = {1'b0, r_exp} + (rlrd_pkg::SEQ_W + 1)'(i_window);
    assign o_ridx    = r_idx;
    assign o_busy    = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_exp      = r_exp;
        n_cmd      = r_cmd;
        n_ck       = r_ck;
        n_txs      = r_txs;
        n_seq      = r_seq;
        n_pay      = r_pay;
        n_found    = r_found;
        n_best     = r_best;
        n_fst      = r_fst;
        n_pend_vld = r_pend_vld;
        n_pend_seq = r_pend_seq;
        n_pend_pay = r_pend_pay;
        n_o_stb    = 1'b0;
        n_o_st     = r_o_st;
        n_o_has    = r_o_has;
        n_o_seq    = r_o_seq;
        n_o_pay    = r_o_pay;
        n_o_last   = r_o_last;
        o_req      = '0;
        single_vld = 1'b0;
        single_st  = rlrd_pkg::ST_DELIVERED;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_command;
                    n_ck    = i_checksum_ok;
                    n_txs   = i_tx_started;
                    n_seq   = i_seq_number;
                    n_pay   = i_payload_tag;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (r_cmd) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_MIN;
                end else if (!r_ck) begin
                    single_vld = 1'b1;
                    single_st  = rlrd_pkg::ST_BAD_CRC;
                end else if (r_exp == '0 && !r_txs && r_seq != '0) begin
                    single_vld = 1'b1;
                    single_st  = rlrd_pkg::ST_FIRST_NZ;
                end else if (r_seq < r_exp) begin
                    single_vld = 1'b1;
                    single_st  = rlrd_pkg::ST_OLD;
                end else if (r_seq == r_exp) begin
                    n_pend_vld = 1'b1;
                    n_pend_seq = r_seq;
                    n_pend_pay = r_pay;
                    n_exp      = r_exp + 1'b1;
                    n_fst      = rlrd_pkg::ST_DELIVERED;
                    n_idx      = '0;
                    n_state    = S_FLUSH;
                end else begin
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                if ({1'b0, r_seq} > win_limit) begin
                    single_vld = 1'b1;
                    single_st  = rlrd_pkg::ST_BEYOND;
                end else begin
                    n_idx   = '0;
                    n_state = S_DUP;
                end
            end
            S_DUP: begin
                if (i_rd_valid && cmp_eq) begin
                    single_vld = 1'b1;
                    single_st  = rlrd_pkg::ST_DUP;
                end else if (r_idx == LAST_IDX) begin
                    single_vld = 1'b1;
                    if (i_stat.count >= i_depth || !i_stat.free_vld) begin
                        single_st = rlrd_pkg::ST_FULL;
                    end else begin
                        single_st  = rlrd_pkg::ST_DEFERRED;
                        o_req.wr   = 1'b1;
                        o_req.widx = i_stat.free_idx;
                        o_req.seq  = r_seq;
                        o_req.pay  = r_pay;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MIN: begin
                if (i_rd_valid && (!r_found || cmp_lt)) begin
                    n_best  = i_rd_seq;
                    n_found = 1'b1;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_MIN_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MIN_END: begin
                if (!r_found) begin
                    single_vld = 1'b1;
                    single_st  = rlrd_pkg::ST_TIMEOUT;
                end else begin
                    n_exp      = r_best;
                    n_fst      = rlrd_pkg::ST_TIMEOUT;
                    n_pend_vld = 1'b0;
                    n_idx      = '0;
                    n_state    = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_rd_valid && cmp_eq) begin
                    // release the held result, hold the new one until the run ends
                    if (r_pend_vld) begin
                        n_o_stb  = 1'b1;
                        n_o_st   = r_fst;
                        n_o_has  = 1'b1;
                        n_o_seq  = r_pend_seq;
                        n_o_pay  = r_pend_pay;
                        n_o_last = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_seq = i_rd_seq;
                    n_pend_pay = i_rd_pay;
                    o_req.clr  = 1'b1;
                    o_req.cidx = r_idx;
                    n_exp      = r_exp + 1'b1;
                    n_idx      = '0;
                end else if (r_idx == LAST_IDX) begin
                    n_o_stb    = 1'b1;
                    n_o_st     = r_fst;
                    n_o_has    = 1'b1;
                    n_o_seq    = r_pend_seq;
                    n_o_pay    = r_pend_pay;
                    n_o_last   = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (single_vld) begin
            n_o_stb  = 1'b1;
            n_o_st   = single_st;
            n_o_has  = 1'b0;
            n_o_seq  = '0;
            n_o_pay  = '0;
            n_o_last = 1'b1;
            n_state  = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_exp      <= '0;
            r_found    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_o_stb    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_exp      <= n_exp;
            r_found    <= n_found;
            r_pend_vld <= n_pend_vld;
            r_o_stb    <= n_o_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmd      <= n_cmd;
        r_ck       <= n_ck;
        r_txs      <= n_txs;
        r_seq      <= n_seq;
        r_pay      <= n_pay;
        r_best     <= n_best;
        r_fst      <= n_fst;
        r_pend_seq <= n_pend_seq;
        r_pend_pay <= n_pend_pay;
        r_o_st     <= n_o_st;
        r_o_has    <= n_o_has;
        r_o_seq    <= n_o_seq;
        r_o_pay    <= n_o_pay;
        r_o_last   <= n_o_last;
    end

    assign o_strobe      = r_o_stb;
    assign o_status      = r_o_st;
    assign o_has_data    = r_o_has;
    assign o_out_seq     = r_o_seq;
    assign o_out_payload = r_o_pay;
    assign o_last        = r_o_last;

    `RLRD_ASSERT_IMP(a_last_idle, o_strobe && o_last, r_state == S_IDLE, "last result while busy")
    `RLRD_ASSERT_IMP(a_nodata_zero, o_strobe && !o_has_data, o_out_seq == '0 && o_out_payload == '0, "dataless result carries data")
    `RLRD_ASSERT_NXT(a_gap_after_last, o_strobe && o_last, !o_strobe, "result right after last")

endmodule

`default_nettype wire

>>> tb/sv/redundant_link_reorder_dedup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Redundant link reorder/dedup testbench
// Walks a short table of directed transactions, then random traffic that
// mostly follows the expected sequence. Typed rows are checked against the
// table, the rest against an in-bench predictor of the reorder store.
// The depth register is changed between phases; sender gaps vary by phase.
// ----------------------------------------------------------------------------

module redundant_link_reorder_dedup_tb;

    localparam logic CMD_RX      = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;
    localparam int   MAX_SHOWN   = 10;
    localparam int   PHASES      = 6;
    localparam int   PHASE_ITEMS = 14;

    typedef enum logic {ROW_PKT, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [rlrd_pkg::ST_W-1:0]  status;
        logic                       has_data;
        logic [rlrd_pkg::SEQ_W-1:0] seq;
        logic [rlrd_pkg::PAY_W-1:0] payload;
        logic                       last;
    } t_delivery;

    typedef struct {
        t_row_kind                  kind;
        logic                       cmd;
        logic                       ck;
        logic                       txs;
        logic [rlrd_pkg::SEQ_W-1:0] seq;
        logic [rlrd_pkg::PAY_W-1:0] pay;
        bit                         typed;
        t_delivery                  want;
    } t_stim_row;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_we      = 1'b0;
    logic [rlrd_pkg::CFG_W-1:0] i_cfg_data    = '0;
    logic                       start         = 1'b0;
    logic                       i_command     = 1'b0;
    logic                       i_checksum_ok = 1'b0;
    logic                       i_tx_started  = 1'b0;
    logic [rlrd_pkg::SEQ_W-1:0] i_seq_number  = '0;
    logic [rlrd_pkg::PAY_W-1:0] i_payload_tag = '0;
    logic                       busy;
    logic                       o_strobe;
    logic [rlrd_pkg::ST_W-1:0]  o_status;
    logic                       o_has_data;
    logic [rlrd_pkg::SEQ_W-1:0] o_out_seq;
    logic [rlrd_pkg::PAY_W-1:0] o_out_payload;
    logic                       o_last;

    // reorder store as the block should hold it
    logic [rlrd_pkg::SEQ_W-1:0] nxt_seq;
    logic                       held_vld [rlrd_pkg::DEFER_DEPTH];
    logic [rlrd_pkg::SEQ_W-1:0] held_seq [rlrd_pkg::DEFER_DEPTH];
    logic [rlrd_pkg::PAY_W-1:0] held_pay [rlrd_pkg::DEFER_DEPTH];
    logic [rlrd_pkg::CFG_W-1:0] depth_cfg;

    t_delivery due[$];
    t_delivery predicted[$];
    t_stim_row stim_table[$];

    int idle_pct    = 13;
    int fault_count = 0;
    int shown       = 0;
    int phase_depth [PHASES] = '{1, 0, 31, 2, 16, 7};

    redundant_link_reorder_dedup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_checksum_ok (i_checksum_ok),
        .i_tx_started  (i_tx_started),
        .i_seq_number  (i_seq_number),
        .i_payload_tag (i_payload_tag),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_has_data    (o_has_data),
        .o_out_seq     (o_out_seq),
        .o_out_payload (o_out_payload),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int eff_depth();
        if (depth_cfg == '0) begin
            return 1;
        end
        if (int'(depth_cfg) > rlrd_pkg::DEFER_DEPTH) begin
            return rlrd_pkg::DEFER_DEPTH;
        end
        return int'(depth_cfg);
    endfunction

    function automatic int find_held(logic [rlrd_pkg::SEQ_W-1:0] s);
        for (int i = 0; i < rlrd_pkg::DEFER_DEPTH; i++) begin
            if (held_vld[i] && held_seq[i] == s) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void note(logic [rlrd_pkg::ST_W-1:0] st, logic has,
                                 logic [rlrd_pkg::SEQ_W-1:0] s,
                                 logic [rlrd_pkg::PAY_W-1:0] p);
        t_delivery d;
        d.status   = st;
        d.has_data = has;
        d.seq      = s;
        d.payload  = p;
        d.last     = 1'b0;
        predicted.push_back(d);
    endfunction

    function automatic void flush_run(logic [rlrd_pkg::ST_W-1:0] st);
        int idx;
        idx = find_held(nxt_seq);
        while (idx >= 0) begin
            note(st, 1'b1, held_seq[idx], held_pay[idx]);
            held_vld[idx] = 1'b0;
            nxt_seq       = nxt_seq + 1'b1;
            idx           = find_held(nxt_seq);
        end
    endfunction

    function automatic void predict_txn(logic cmd, logic ck, logic txs,
                                        logic [rlrd_pkg::SEQ_W-1:0] s,
                                        logic [rlrd_pkg::PAY_W-1:0] p);
        int                       best;
        int                       used;
        int                       free_idx;
        int                       held;
        logic [rlrd_pkg::SEQ_W:0] limit;
        t_delivery                d;
        predicted.delete();
        if (cmd == CMD_TIMEOUT) begin
            best = -1;
            for (int i = 0; i < rlrd_pkg::DEFER_DEPTH; i++) begin
                if (held_vld[i] && (best < 0 || held_seq[i] < held_seq[best])) begin
                    best = i;
                end
            end
            if (best < 0) begin
                note(rlrd_pkg::ST_TIMEOUT, 1'b0, '0, '0);
            end else begin
                nxt_seq = held_seq[best];
                flush_run(rlrd_pkg::ST_TIMEOUT);
            end
        end else if (!ck) begin
            note(rlrd_pkg::ST_BAD_CRC, 1'b0, '0, '0);
        end else if (nxt_seq == '0 && !txs && s != '0) begin
            note(rlrd_pkg::ST_FIRST_NZ, 1'b0, '0, '0);
        end else if (s < nxt_seq) begin
            note(rlrd_pkg::ST_OLD, 1'b0, '0, '0);
        end else if (s == nxt_seq) begin
            note(rlrd_pkg::ST_DELIVERED, 1'b1, s, p);
            nxt_seq = nxt_seq + 1'b1;
            flush_run(rlrd_pkg::ST_DELIVERED);
        end else begin
            used     = eff_depth();
            limit    = {1'b0, nxt_seq} +
                       (rlrd_pkg::SEQ_W + 1)'(used * rlrd_pkg::WINDOW_FACTOR);
            held     = 0;
            free_idx = -1;
            for (int i = 0; i < rlrd_pkg::DEFER_DEPTH; i++) begin
                if (held_vld[i]) begin
                    held++;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if ({1'b0, s} > limit) begin
                note(rlrd_pkg::ST_BEYOND, 1'b0, '0, '0);
            end else if (find_held(s) >= 0) begin
                note(rlrd_pkg::ST_DUP, 1'b0, '0, '0);
            end else if (held >= used || free_idx < 0) begin
                note(rlrd_pkg::ST_FULL, 1'b0, '0, '0);
            end else begin
                held_vld[free_idx] = 1'b1;
                held_seq[free_idx] = s;
                held_pay[free_idx] = p;
                note(rlrd_pkg::ST_DEFERRED, 1'b0, '0, '0);
            end
        end
        d      = predicted.pop_back();
        d.last = 1'b1;
        predicted.push_back(d);
    endfunction

    function automatic void add_row(t_row_kind k, logic cmd, logic ck, logic txs,
                                    logic [rlrd_pkg::SEQ_W-1:0] s,
                                    logic [rlrd_pkg::PAY_W-1:0] p, bit typed,
                                    logic [rlrd_pkg::ST_W-1:0] st, logic has,
                                    logic [rlrd_pkg::SEQ_W-1:0] os,
                                    logic [rlrd_pkg::PAY_W-1:0] op);
        t_stim_row r;
        r.kind  = k;
        r.cmd   = cmd;
        r.ck    = ck;
        r.txs   = txs;
        r.seq   = s;
        r.pay   = p;
        r.typed = typed;
        r.want  = {st, has, os, op, 1'b1};
        stim_table.push_back(r);
    endfunction

    task automatic send_item(logic cmd, logic ck, logic txs,
                             logic [rlrd_pkg::SEQ_W-1:0] s,
                             logic [rlrd_pkg::PAY_W-1:0] p, bit typed, t_delivery want);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) begin
            gap = int'($urandom_range(24, 1));
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_command     <= cmd;
        i_checksum_ok <= ck;
        i_tx_started  <= txs;
        i_seq_number  <= s;
        i_payload_tag <= p;
        do @(posedge i_clk); while (busy);
        predict_txn(cmd, ck, txs, s, p);
        if (typed) begin
            due.push_back(want);
        end else begin
            foreach (predicted[i]) begin
                due.push_back(predicted[i]);
            end
        end
    endtask

    task automatic write_depth(logic [rlrd_pkg::CFG_W-1:0] v);
        start <= 1'b0;
        @(posedge i_clk);
        while (due.size() != 0 || busy) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        depth_cfg  = v;
    endtask

    task automatic send_random();
        logic                       cmd;
        logic                       ck;
        logic                       txs;
        logic [rlrd_pkg::SEQ_W-1:0] s;
        int                         roll;
        int                         win;
        int                         idx;
        t_delivery                  none;
        none = '0;
        roll = int'($urandom_range(99));
        win  = eff_depth() * rlrd_pkg::WINDOW_FACTOR;
        cmd  = CMD_RX;
        ck   = 1'b1;
        txs  = ($urandom_range(9) != 0);
        s    = nxt_seq;
        if (roll < 9) begin
            cmd = CMD_TIMEOUT;
            ck  = 1'($urandom_range(1));
            s   = $urandom();
        end else if (roll < 15) begin
            ck = 1'b0;
            s  = $urandom();
        end else if (roll < 45) begin
            s = nxt_seq;
        end else if (roll < 70) begin
            s = nxt_seq + $urandom_range(4, 1);
        end else if (roll < 78) begin
            s = nxt_seq + $urandom_range(win + 2, 5);
        end else if (roll < 83) begin
            s = nxt_seq + win + $urandom_range(1);
        end else if (roll < 89) begin
            // hit a held entry when there is one
            idx = int'($urandom_range(rlrd_pkg::DEFER_DEPTH - 1));
            s   = nxt_seq + 1'b1;
            for (int i = 0; i < rlrd_pkg::DEFER_DEPTH; i++) begin
                if (held_vld[(idx + i) % rlrd_pkg::DEFER_DEPTH]) begin
                    s = held_seq[(idx + i) % rlrd_pkg::DEFER_DEPTH];
                end
            end
        end else if (roll < 95) begin
            if (nxt_seq != '0) begin
                s = nxt_seq - $urandom_range((nxt_seq < 20) ? int'(nxt_seq) : 20, 1);
            end else begin
                txs = 1'b0;
                s   = $urandom();
            end
        end else begin
            txs = 1'($urandom_range(1));
            s   = $urandom();
        end
        send_item(cmd, ck, txs, s, $urandom(), 1'b0, none);
    endtask

    always @(posedge i_clk) begin : check_results
        t_delivery got;
        t_delivery want;
        if (i_rst_n && o_strobe) begin
            got = {o_status, o_has_data, o_out_seq, o_out_payload, o_last};
            if (due.size() == 0) begin
                fault_count++;
                if (shown < MAX_SHOWN) begin
                    shown++;
                    $display("%0t: unexpected transaction status=%0d has=%0b seq=%h %s",
                             $realtime, got.status, got.has_data, got.seq,
                             $sformatf("pay=%h last=%0b", got.payload, got.last));
                end
            end else begin
                want = due.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (shown < MAX_SHOWN) begin
                        shown++;
                        $display("%0t: mismatch exp status=%0d has=%0b seq=%h pay=%h last=%0b",
                                 $realtime, want.status, want.has_data, want.seq,
                                 want.payload, want.last);
                        $display("%0t:          got status=%0d has=%0b seq=%h pay=%h last=%0b",
                                 $realtime, got.status, got.has_data, got.seq,
                                 got.payload, got.last);
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        nxt_seq   = '0;
        depth_cfg = rlrd_pkg::CFG_RESET;
        for (int i = 0; i < rlrd_pkg::DEFER_DEPTH; i++) begin
            held_vld[i] = 1'b0;
            held_seq[i] = '0;
            held_pay[i] = '0;
        end

        add_row(ROW_PKT, CMD_RX, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                rlrd_pkg::ST_BAD_CRC, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b0, 32'd5, 32'h0000_0001, 1'b1,
                rlrd_pkg::ST_FIRST_NZ, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1,
                rlrd_pkg::ST_FIRST_NZ, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_TIMEOUT, 1'b1, 1'b1, 32'h0, 32'h0, 1'b1,
                rlrd_pkg::ST_TIMEOUT, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b1,
                rlrd_pkg::ST_DELIVERED, 1'b1, 32'h0, 32'hFFFF_FFFF);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'h0, 32'h0, 1'b1,
                rlrd_pkg::ST_OLD, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd3, 32'h1234_5678, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd2, 32'h0, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd2, 32'hFFFF_FFFF, 1'b1,
                rlrd_pkg::ST_DUP, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd161, 32'hA5A5_5A5A, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd162, 32'h0, 1'b1,
                rlrd_pkg::ST_BEYOND, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b1,
                rlrd_pkg::ST_BEYOND, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd1, 32'hDEAD_0001, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b0, 32'h0, 32'h0, 1'b1,
                rlrd_pkg::ST_OLD, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd6, 32'h0000_0006, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd8, 32'h8000_0008, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_TIMEOUT, 1'b1, 1'b1, 32'h0, 32'h0, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_TIMEOUT, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_TIMEOUT, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_TIMEOUT, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1,
                rlrd_pkg::ST_TIMEOUT, 1'b0, '0, '0);
        add_row(ROW_CFG, CMD_RX, 1'b0, 1'b0, 32'd1, 32'h0, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd164, 32'h0000_00A4, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd165, 32'h0, 1'b1,
                rlrd_pkg::ST_FULL, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd173, 32'h0, 1'b1,
                rlrd_pkg::ST_BEYOND, 1'b0, '0, '0);
        add_row(ROW_PKT, CMD_RX, 1'b1, 1'b1, 32'd162, 32'h7FFF_FFFF, 1'b0,
                rlrd_pkg::ST_DELIVERED, 1'b0, '0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[n]) begin
            if (stim_table[n].kind == ROW_CFG) begin
                write_depth(rlrd_pkg::CFG_W'(stim_table[n].seq));
            end else begin
                send_item(stim_table[n].cmd, stim_table[n].ck, stim_table[n].txs,
                          stim_table[n].seq, stim_table[n].pay, stim_table[n].typed,
                          stim_table[n].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct = (ph < 2) ? 13 : ((ph < 4) ? 57 : 0);
            write_depth(rlrd_pkg::CFG_W'(phase_depth[ph]));
            repeat (PHASE_ITEMS) send_random();
        end

        // hold off until every result is back
        start <= 1'b0;
        while (due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
